@@ hdl/pip_pkg.sv @@
// Shared types for the point-in-polygon test unit.
// Used by pip_edge_unit and point_in_polygon_test_unit; no dependencies.
`timescale 1ns / 1ps

package pip_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } t_state;

    // sequencer -> edge unit, one vertex read result per cycle
    typedef struct packed {
        logic clear;   // start of a query: reset crossing parity
        logic vld;     // read data valid this cycle
        logic first;   // read data is the closing vertex (j = n-1)
    } t_edge_ctl;

    // edge unit -> sequencer
    typedef struct packed {
        logic busy;    // edges still in flight
        logic odd;     // crossing parity so far
    } t_edge_sts;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

endpackage

@@ hdl/point_in_polygon_test_unit.sv @@
// Point-in-polygon test unit, top level: sequencer, config register, output.
// Depends on pip_pkg, pip_vertex_store and pip_edge_unit.
//
// Input channel (i_in_valid / o_in_stall): a load transaction (operation 0)
// writes vertex (coord_x, coord_y) to slot vertex_index and gives no result;
// slots at or beyond MAX_VERTICES are dropped. A query transaction
// (operation 1) tests point (coord_x, coord_y) against the first
// vertex_count stored vertices as a closed polygon and gives one inside_res.
// Config channel (i_cfg_valid / o_cfg_ready): writes vertex_count; ready is
// always high. Counts above MAX_VERTICES are used as MAX_VERTICES.
// Sequencing: a load is accepted while the sequencer is idle. A query reads the
// store once per cycle, closing vertex first, then vertices 0 .. n-1 (n =
// clamped count; none for n = 0); the input stalls until the result is loaded
// into the output register. The single RAM read port sets this read rate.
// Output channel (o_out_valid / i_out_stall): one result register. Loads
// keep flowing while a result waits; a finished query holds in its drain
// step until the result register is free.
// Reset clears the count, sequencer and output valid. Vertex slots are
// undefined until loaded.
`timescale 1ns / 1ps

module point_in_polygon_test_unit
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_vertex_index,
    input  logic signed [COORD_BITS-1:0] i_coord_x,
    input  logic signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_inside_res
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int W  = COORD_BITS;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, r_n, n_n, r_cnt, n_cnt;
    logic signed [W-1:0] r_px, r_py;
    logic r_rd_vld, r_rd_first, r_out_vld, n_out_vld, r_out_inside;

    logic          accept, take_out, wr_en, rd_en, clear, load_out;
    logic [IW-1:0] rd_addr;
    logic [CW-1:0] clamp;
    logic [CW-1:0] rd_idx;
    logic [2*W-1:0] rd_data;
    t_edge_ctl     ctl;
    t_edge_sts     sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign take_out    = r_out_vld && !i_out_stall;
    assign wr_en       = accept && (i_operation == OP_LOAD)
                         && ((IW+1)'(i_vertex_index) < (IW+1)'(MAX_VERTICES));
    assign clamp = (r_count > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_count <= i_cfg_data;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_cnt    = r_cnt;
        rd_en    = 1'b0;
        clear    = 1'b0;
        load_out = 1'b0;
        // closing vertex first, then vertices 0 .. n-1
        rd_idx   = (r_cnt == '0) ? r_n - CW'(1) : r_cnt - CW'(1);
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_operation == OP_QUERY)) begin
                    clear   = 1'b1;
                    n_n     = clamp;
                    n_cnt   = '0;
                    n_state = (clamp == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en = 1'b1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !sts.busy && (!r_out_vld || !i_out_stall)) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_vld = load_out ? 1'b1 : (take_out ? 1'b0 : r_out_vld);
    end

    assign rd_addr = rd_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_en;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_rd_first <= rd_en && (r_cnt == '0);
        if (accept) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (load_out) begin
            r_out_inside <= sts.odd;
        end
    end

    assign ctl.clear = clear;
    assign ctl.vld   = r_rd_vld;
    assign ctl.first = r_rd_first;

    pip_vertex_store #(
        .DEPTH (MAX_VERTICES),
        .AW    (IW),
        .DW    (2 * W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_vertex_index),
        .i_wdata ({i_coord_x, i_coord_y}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    pip_edge_unit #(
        .W (W)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_vx    (rd_data[2*W-1:W]),
        .i_vy    (rd_data[W-1:0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_sts   (sts)
    );

    assign o_out_valid  = r_out_vld;
    assign o_inside_res = r_out_inside;

endmodule

@@ hdl/pip_vertex_store.sv @@
// Vertex store: simple dual-port synchronous RAM, one write and one
// registered read port. No dependencies.
`timescale 1ns / 1ps

module pip_vertex_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pip_edge_unit.sv @@
// Edge crossing pipeline: differences, cross-multiply, compare and toggle.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_edge_ctl           i_ctl,
    input  logic signed [W-1:0] i_vx,
    input  logic signed [W-1:0] i_vy,
    input  logic signed [W-1:0] i_px,
    input  logic signed [W-1:0] i_py,
    output t_edge_sts           o_sts
);

    localparam int PW = 2 * W + 2;

    logic signed [W-1:0] r_prev_x, r_prev_y;
    logic signed [W:0]   r_a, r_b, r_d, r_e;
    logic signed [PW-1:0] r_p, r_q;
    logic r_v1, r_s1, r_v2, r_s2, r_inside;

    logic signed [W:0] n_a, n_b, n_d, n_e, dy, ey;
    logic              n_s;

    always_comb begin
        n_a = (W+1)'(i_px) - (W+1)'(i_vx);
        n_b = (W+1)'(r_prev_x) - (W+1)'(i_vx);
        dy  = (W+1)'(r_prev_y) - (W+1)'(i_vy);
        ey  = (W+1)'(i_py) - (W+1)'(i_vy);
        // fold the sign of the y span into e so the compare needs no flip
        if (dy < 0) begin
            n_d = -dy;
            n_e = -ey;
        end else begin
            n_d = dy;
            n_e = ey;
        end
        n_s = (i_vy > i_py) != (r_prev_y > i_py);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_v1 <= i_ctl.vld && !i_ctl.first;
            r_v2 <= r_v1;
            if (r_v2 && r_s2 && (r_p < r_q)) begin
                r_inside <= !r_inside;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prev_x <= i_vx;
            r_prev_y <= i_vy;
            r_a      <= n_a;
            r_b      <= n_b;
            r_d      <= n_d;
            r_e      <= n_e;
            r_s1     <= n_s;
        end
        r_p  <= r_a * r_d;
        r_q  <= r_b * r_e;
        r_s2 <= r_s1;
    end

    assign o_sts.busy = r_v1 || r_v2;
    assign o_sts.odd  = r_inside;

endmodule
